FILE: design/bes_pkg.sv
package bes_pkg;

   localparam int REG_SLOTS = 4;
   localparam int CHAR_W = 8;
   localparam int LEN_W = 4;
   localparam int SLOT_W = 2;
   localparam int REPL_W = 64;
   localparam int COUNT_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam int DEF_SPECIAL_SLOTS = 4;
   localparam int DEF_MAX_REPLACE_LEN = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CHARS   = 3'd0,
      REG_COUNT   = 3'd1,
      REG_LENGTHS = 3'd2,
      REG_REPL0   = 3'd3,
      REG_REPL1   = 3'd4,
      REG_REPL2   = 3'd5,
      REG_REPL3   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [REG_SLOTS*CHAR_W-1:0]          chars;
      logic [COUNT_W-1:0]                   count;
      logic [REG_SLOTS*LEN_W-1:0]           lengths;
      logic [REG_SLOTS-1:0][REPL_W-1:0]     repl;
   } cfg_type;

   typedef struct packed {
      logic [CHAR_W-1:0] data;
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  len;
   } entry_type;

endpackage

FILE: design/byte_escape_substitution.sv
// byte escape substitution
// input queue side: drive req_in_byte with req_push; a word is taken at a clock edge
// where req_push is high and req_full is low.
// result queue side: while rsp_empty is low the oldest result word is on rsp_out_byte,
// rsp_run_last and rsp_was_replaced; rsp_pop takes it.
// a byte matching an active special slot becomes that slot's replacement string,
// otherwise it passes through; a zero-length replacement deletes the byte.
// configuration over the csr_ port, 64-bit registers at byte address 8*index; the user
// must write them only while no word is in flight, the block does not enforce it.
// a pushed word is stored in the queue, then loaded into the output register before it
// shows on the result side. one pass-through byte per cycle while the receiver pops; a
// replaced byte holds the back end until its last byte is in the single output register.
// a two-entry queue between the classifier and the expander lets input keep
// flowing while a replacement drains; when the receiver stalls, the output register
// holds and the queue fills, then req_full rises.
// reset clears the configuration registers and empties both queues.
module byte_escape_substitution #(
   parameter int SPECIAL_SLOTS   = bes_pkg::DEF_SPECIAL_SLOTS,
   parameter int MAX_REPLACE_LEN = bes_pkg::DEF_MAX_REPLACE_LEN
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [bes_pkg::CHAR_W-1:0]     req_in_byte,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [bes_pkg::CHAR_W-1:0]     rsp_out_byte,
   output logic                           rsp_run_last,
   output logic                           rsp_was_replaced,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bes_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bes_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bes_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bes_pkg::*;

   cfg_type   cfg;
   entry_type entry;
   entry_type head;
   logic      keep;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;

   assign req_full = q_full;

   bes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bes_front #(
      .SPECIAL_SLOTS   (SPECIAL_SLOTS),
      .MAX_REPLACE_LEN (MAX_REPLACE_LEN)
   ) u_front (
      .cfg     (cfg),
      .in_byte (req_in_byte),
      .entry   (entry),
      .keep    (keep)
   );

   bes_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push & keep),
      .push_data (entry),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   bes_back #(
      .MAX_REPLACE_LEN (MAX_REPLACE_LEN)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_empty          (q_empty),
      .head             (head),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_was_replaced (rsp_was_replaced)
   );

endmodule

FILE: design/bes_csr.sv
module bes_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bes_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bes_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bes_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output bes_pkg::cfg_type               cfg
);
   import bes_pkg::*;

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   logic [CSR_IDX_W-1:0]     index;
   logic                     wr_en;

   assign index = csr_paddr[CSR_ADDR_W-1 -: CSR_IDX_W];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_CHARS:   cfg_in.chars = csr_pwdata[REG_SLOTS*CHAR_W-1:0];
            REG_COUNT:   cfg_in.count = csr_pwdata[COUNT_W-1:0];
            REG_LENGTHS: cfg_in.lengths = csr_pwdata[REG_SLOTS*LEN_W-1:0];
            REG_REPL0:   cfg_in.repl[0] = csr_pwdata[REPL_W-1:0];
            REG_REPL1:   cfg_in.repl[1] = csr_pwdata[REPL_W-1:0];
            REG_REPL2:   cfg_in.repl[2] = csr_pwdata[REPL_W-1:0];
            REG_REPL3:   cfg_in.repl[3] = csr_pwdata[REPL_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_CHARS:   csr_prdata = CSR_DATA_W'(cfg_ff.chars);
         REG_COUNT:   csr_prdata = CSR_DATA_W'(cfg_ff.count);
         REG_LENGTHS: csr_prdata = CSR_DATA_W'(cfg_ff.lengths);
         REG_REPL0:   csr_prdata = CSR_DATA_W'(cfg_ff.repl[0]);
         REG_REPL1:   csr_prdata = CSR_DATA_W'(cfg_ff.repl[1]);
         REG_REPL2:   csr_prdata = CSR_DATA_W'(cfg_ff.repl[2]);
         REG_REPL3:   csr_prdata = CSR_DATA_W'(cfg_ff.repl[3]);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/bes_front.sv
module bes_front #(
   parameter int SPECIAL_SLOTS   = bes_pkg::DEF_SPECIAL_SLOTS,
   parameter int MAX_REPLACE_LEN = bes_pkg::DEF_MAX_REPLACE_LEN
) (
   input  bes_pkg::cfg_type             cfg,
   input  logic [bes_pkg::CHAR_W-1:0]   in_byte,
   output bes_pkg::entry_type           entry,
   output logic                         keep
);
   import bes_pkg::*;

   localparam int ACTIVE_MAX = (SPECIAL_SLOTS < REG_SLOTS) ? SPECIAL_SLOTS : REG_SLOTS;

   logic              hit;
   logic [SLOT_W-1:0] slot;
   logic [LEN_W-1:0]  nibble;
   logic [LEN_W-1:0]  len;

   // highest matching active slot wins
   always_comb begin
      hit = 1'b0;
      slot = '0;
      for (int i = 0; i < ACTIVE_MAX; i++) begin
         if ((i < int'(cfg.count)) && (cfg.chars[i*CHAR_W +: CHAR_W] == in_byte)) begin
            hit = 1'b1;
            slot = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      nibble = cfg.lengths[slot*LEN_W +: LEN_W];
      if (nibble > LEN_W'(MAX_REPLACE_LEN)) begin
         len = LEN_W'(MAX_REPLACE_LEN);
      end else begin
         len = nibble;
      end
   end

   always_comb begin
      entry.data = in_byte;
      entry.hit = hit;
      entry.slot = slot;
      entry.len = len;
      keep = !hit || (len != '0);
   end

endmodule

FILE: design/bes_queue.sv
module bes_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bes_pkg::entry_type  push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output bes_pkg::entry_type  head
);
   import bes_pkg::*;

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = mem_ff[rd_ptr_ff];
   assign do_push = push & !full;
   assign do_pop = pop & !empty;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/bes_back.sv
module bes_back #(
   parameter int MAX_REPLACE_LEN = bes_pkg::DEF_MAX_REPLACE_LEN
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bes_pkg::cfg_type            cfg,
   input  logic                        q_empty,
   input  bes_pkg::entry_type          head,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [bes_pkg::CHAR_W-1:0]  rsp_out_byte,
   output logic                        rsp_run_last,
   output logic                        rsp_was_replaced
);
   import bes_pkg::*;

   localparam int IDX_W = (MAX_REPLACE_LEN > 1) ? $clog2(MAX_REPLACE_LEN) : 1;

   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;
   logic              valid_ff;
   logic              valid_in;
   logic [CHAR_W-1:0] byte_ff;
   logic [CHAR_W-1:0] byte_in;
   logic              last_ff;
   logic              last_in;
   logic              repl_ff;
   logic              repl_in;
   logic [REPL_W-1:0] repl_word;
   logic [LEN_W-1:0]  idx_plus;
   logic              advance;
   logic              last;

   assign advance = !q_empty && (!valid_ff || rsp_pop);
   assign repl_word = cfg.repl[head.slot];
   assign idx_plus = LEN_W'(idx_ff) + LEN_W'(1);
   assign last = !head.hit || (idx_plus == head.len);
   assign q_pop = advance && last;

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff && !rsp_pop;
      byte_in = byte_ff;
      last_in = last_ff;
      repl_in = repl_ff;
      if (advance) begin
         idx_in = last ? '0 : IDX_W'(idx_plus);
         valid_in = 1'b1;
         byte_in = head.hit ? CHAR_W'(repl_word >> {idx_ff, 3'b000}) : head.data;
         last_in = last;
         repl_in = head.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      repl_ff <= repl_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = last_ff;
   assign rsp_was_replaced = repl_ff;

endmodule

FILE: design/bes_checker.sv
module bes_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_full,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic [bes_pkg::CHAR_W-1:0] rsp_out_byte,
   input logic                       rsp_run_last,
   input logic                       rsp_was_replaced,
   input logic                       csr_pready
);
   import bes_pkg::*;

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_was_replaced)))
      else $error("result word changed while stalled");

   // a passed-through byte is always the only word of its run
   a_pass_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_was_replaced) |-> rsp_run_last)
      else $error("pass-through word without run_last");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_ready: assert property (@(posedge clock) csr_pready)
      else $error("csr_pready low");

endmodule

bind byte_escape_substitution bes_checker u_bes_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_run_last     (rsp_run_last),
   .rsp_was_replaced (rsp_was_replaced),
   .csr_pready       (csr_pready)
);
